[rtl/etrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrs_pkg
// Shared widths, codes and types of the extent table request splitter.
// ----------------------------------------------------------------------------
package etrs_pkg;

    localparam int ENT_W           = 48;
    localparam int LEN_W           = 17;
    localparam int IDX_W           = 3;
    localparam int CFG_W           = 4;
    localparam int DEF_NUM_ENTRIES = 8;
    localparam int BLOCK_BYTES     = 512;
    localparam int BLOCK_SHIFT     = $clog2(BLOCK_BYTES);
    localparam int MAX_REQ_BYTES   = 65536;
    // Byte addresses: (start + length) * BLOCK_BYTES never exceeds this width.
    localparam int BYTE_W          = ENT_W + 1 + BLOCK_SHIFT;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic KIND_PIECE = 1'b0;
    localparam logic KIND_RESID = 1'b1;

    localparam logic [1:0] TOK_ENTRY = 2'd0;
    localparam logic [1:0] TOK_RESID = 2'd1;
    localparam logic [1:0] TOK_FLUSH = 2'd2;

    // Classified item handed from the front end to the walker.
    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  entry_index;
        logic [ENT_W-1:0]  entry_start;
        logic [ENT_W-1:0]  entry_count;
        logic [BYTE_W-1:0] req_lo;
        logic [BYTE_W-1:0] req_hi;
        logic [LEN_W-1:0]  req_len;
        logic [CFG_W-1:0]  used_raw;
    } t_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] idx;
    } t_tok;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  hit_index;
        logic [LEN_W-1:0]  request_offset;
        logic [LEN_W-1:0]  piece_bytes;
        logic [ENT_W-1:0]  target_block;
        logic              last;
    } t_result;

endpackage

[rtl/extent_table_request_splitter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extent_table_request_splitter_unit
// Splits block requests across a table of extents and reports uncovered bytes.
// ----------------------------------------------------------------------------
// A write beat (op 0) loads one table slot in the walker. A request beat
// (op 1) is checked against entries 0 .. entries_in_use-1, one entry per
// cycle while the output is not stalled, through a four-stage overlap
// pipeline, followed by two closing steps; the walker then drains its
// pipeline before taking the next queued beat. Results come out in entry
// order, the residual beat (if any) last, with last set on the final beat;
// a zero-byte request yields no beats. A two-entry queue lets new beats be
// accepted while a request is being walked; the walker stalls while a result
// waits in the output register and is not taken.
// ----------------------------------------------------------------------------
module extent_table_request_splitter_unit #(
    parameter int NUM_ENTRIES = etrs_pkg::DEF_NUM_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [etrs_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [etrs_pkg::ENT_W-1:0]  i_entry_start_block,
    input  logic [etrs_pkg::ENT_W-1:0]  i_entry_block_count,
    input  logic [etrs_pkg::ENT_W-1:0]  i_req_block,
    input  logic [etrs_pkg::LEN_W-1:0]  i_req_bytes,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [etrs_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_kind,
    output logic [etrs_pkg::IDX_W-1:0]  o_hit_index,
    output logic [etrs_pkg::LEN_W-1:0]  o_request_offset,
    output logic [etrs_pkg::LEN_W-1:0]  o_piece_bytes,
    output logic [etrs_pkg::ENT_W-1:0]  o_target_block,
    output logic                        o_last
);

    etrs_pkg::t_item   front_item;
    logic              front_valid;
    logic              front_ready;
    etrs_pkg::t_item   queue_item;
    logic              queue_valid;
    logic              queue_ready;
    etrs_pkg::t_result result;

    etrs_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_op                (i_op),
        .i_entry_index       (i_entry_index),
        .i_entry_start_block (i_entry_start_block),
        .i_entry_block_count (i_entry_block_count),
        .i_req_block         (i_req_block),
        .i_req_bytes         (i_req_bytes),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_item              (front_item),
        .o_item_valid        (front_valid),
        .i_item_ready        (front_ready)
    );

    etrs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_item  (front_item),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .o_pop_item   (queue_item),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready)
    );

    etrs_back #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (queue_item),
        .i_item_valid   (queue_valid),
        .o_item_ready   (queue_ready),
        .o_result       (result),
        .o_result_valid (o_valid),
        .i_result_ready (i_ready)
    );

    assign o_kind           = result.kind;
    assign o_hit_index      = result.hit_index;
    assign o_request_offset = result.request_offset;
    assign o_piece_bytes    = result.piece_bytes;
    assign o_target_block   = result.target_block;
    assign o_last           = result.last;

endmodule

[rtl/etrs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrs_front
// Accepts input beats, holds the configuration register and turns a request
// into its clamped length and byte range before queuing it.
// ----------------------------------------------------------------------------
module etrs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [etrs_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [etrs_pkg::ENT_W-1:0]    i_entry_start_block,
    input  logic [etrs_pkg::ENT_W-1:0]    i_entry_block_count,
    input  logic [etrs_pkg::ENT_W-1:0]    i_req_block,
    input  logic [etrs_pkg::LEN_W-1:0]    i_req_bytes,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [etrs_pkg::CFG_W-1:0]    i_cfg_data,
    output etrs_pkg::t_item               o_item,
    output logic                          o_item_valid,
    input  logic                          i_item_ready
);

    logic                         r_vld;
    etrs_pkg::t_item              r_item;
    etrs_pkg::t_item              n_item;
    logic [etrs_pkg::CFG_W-1:0]   r_cfg;
    logic                         accept;

    assign o_ready      = !r_vld || i_item_ready;
    assign accept       = i_valid && o_ready;
    assign o_cfg_ready  = 1'b1;
    assign o_item       = r_item;
    assign o_item_valid = r_vld;

    always_comb begin
        logic [etrs_pkg::LEN_W-1:0] len;
        logic [etrs_pkg::BYTE_W-1:0] lo;
        if (i_req_bytes > etrs_pkg::LEN_W'(etrs_pkg::MAX_REQ_BYTES)) begin
            len = etrs_pkg::LEN_W'(etrs_pkg::MAX_REQ_BYTES);
        end else begin
            len = i_req_bytes;
        end
        lo = {1'b0, i_req_block, {etrs_pkg::BLOCK_SHIFT{1'b0}}};
        n_item.op          = i_op;
        n_item.entry_index = i_entry_index;
        n_item.entry_start = i_entry_start_block;
        n_item.entry_count = i_entry_block_count;
        n_item.req_lo      = lo;
        n_item.req_hi      = lo + etrs_pkg::BYTE_W'(len);
        n_item.req_len     = len;
        n_item.used_raw    = r_cfg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_cfg <= '0;
        end else begin
            if (accept) begin
                r_vld <= 1'b1;
            end else if (i_item_ready) begin
                r_vld <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

[rtl/etrs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrs_queue
// Two-entry queue that decouples the front end from the table walker.
// ----------------------------------------------------------------------------
module etrs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  etrs_pkg::t_item   i_push_item,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    output etrs_pkg::t_item   o_pop_item,
    output logic              o_pop_valid,
    input  logic              i_pop_ready
);

    etrs_pkg::t_item r_head;
    etrs_pkg::t_item r_tail;
    etrs_pkg::t_item n_head;
    etrs_pkg::t_item n_tail;
    logic            r_head_vld;
    logic            r_tail_vld;
    logic            n_head_vld;
    logic            n_tail_vld;
    logic            push;
    logic            pop;

    assign o_push_ready = !r_tail_vld;
    assign push         = i_push_valid && !r_tail_vld;
    assign pop          = i_pop_ready && r_head_vld;
    assign o_pop_item   = r_head;
    assign o_pop_valid  = r_head_vld;

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_head_vld = r_head_vld;
        n_tail_vld = r_tail_vld;
        case ({push, pop})
            2'b10: begin
                if (!r_head_vld) begin
                    n_head     = i_push_item;
                    n_head_vld = 1'b1;
                end else begin
                    n_tail     = i_push_item;
                    n_tail_vld = 1'b1;
                end
            end
            2'b01: begin
                n_head     = r_tail;
                n_head_vld = r_tail_vld;
                n_tail_vld = 1'b0;
            end
            2'b11: begin
                if (r_tail_vld) begin
                    n_head = r_tail;
                    n_tail = i_push_item;
                end else begin
                    n_head = i_push_item;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_tail_vld <= 1'b0;
        end else begin
            r_head_vld <= n_head_vld;
            r_tail_vld <= n_tail_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

endmodule

[rtl/etrs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etrs_back
// Owns the extent table, walks the used entries of each request through a
// four-stage overlap pipeline and assembles the result beats.
// ----------------------------------------------------------------------------
module etrs_back #(
    parameter int NUM_ENTRIES = etrs_pkg::DEF_NUM_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  etrs_pkg::t_item   i_item,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    output etrs_pkg::t_result o_result,
    output logic              o_result_valid,
    input  logic              i_result_ready
);

    localparam int AW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_TRES  = 2'd2;
    localparam logic [1:0] ST_TFLSH = 2'd3;

    logic [etrs_pkg::ENT_W-1:0] mem_start [NUM_ENTRIES];
    logic [etrs_pkg::ENT_W-1:0] mem_count [NUM_ENTRIES];

    // Sequencer
    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [CNT_W-1:0]            r_seq_idx;
    logic [CNT_W-1:0]            n_seq_idx;
    logic [CNT_W-1:0]            r_used;
    logic [CNT_W-1:0]            n_used;
    logic [etrs_pkg::BYTE_W-1:0] r_req_lo;
    logic [etrs_pkg::BYTE_W-1:0] r_req_hi;
    logic [etrs_pkg::LEN_W-1:0]  r_req_len;
    logic                        load;
    logic                        load_req;
    logic                        mem_we;
    logic                        tok_vld;
    etrs_pkg::t_tok              tok;
    logic                        adv;
    logic                        pipe_empty;

    // Pipeline
    logic                        r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    etrs_pkg::t_tok              r_s1_tok, r_s2_tok, r_s3_tok, r_s4_tok;
    logic [etrs_pkg::ENT_W-1:0]  r_s1_start;
    logic [etrs_pkg::ENT_W-1:0]  r_s1_count;
    logic [etrs_pkg::BYTE_W-1:0] r_s2_ent_lo;
    logic [etrs_pkg::BYTE_W-1:0] r_s2_ent_hi;
    logic [etrs_pkg::BYTE_W-1:0] r_s3_lo;
    logic [etrs_pkg::BYTE_W-1:0] r_s3_hi;
    logic [etrs_pkg::BYTE_W-1:0] r_s3_ent_lo;
    logic                        r_s4_hit;
    logic [etrs_pkg::LEN_W-1:0]  r_s4_off;
    logic [etrs_pkg::LEN_W-1:0]  r_s4_bytes;
    logic [etrs_pkg::ENT_W-1:0]  r_s4_target;
    logic [etrs_pkg::BYTE_W-1:0] s4_diff;

    // Result assembly
    localparam int ISS_W = etrs_pkg::LEN_W + CNT_W;
    logic [ISS_W-1:0]            r_issued;
    logic                        r_hold_vld;
    etrs_pkg::t_result           r_hold;
    etrs_pkg::t_result           hold_final;
    logic                        r_out_vld;
    etrs_pkg::t_result           r_out;

    assign adv        = !r_out_vld || i_result_ready;
    assign pipe_empty = !(r_s1_vld || r_s2_vld || r_s3_vld || r_s4_vld);
    assign o_item_ready = (r_state == ST_IDLE) && pipe_empty;
    assign load       = i_item_valid && o_item_ready;
    assign load_req   = load && (i_item.op == etrs_pkg::OP_REQUEST);
    assign mem_we     = load && (i_item.op == etrs_pkg::OP_WRITE)
                        && (32'(i_item.entry_index) < NUM_ENTRIES);

    always_comb begin
        n_state   = r_state;
        n_seq_idx = r_seq_idx;
        n_used    = r_used;
        tok_vld   = 1'b0;
        tok.kind  = etrs_pkg::TOK_ENTRY;
        tok.idx   = etrs_pkg::IDX_W'(r_seq_idx);
        case (r_state)
            ST_IDLE: begin
                if (load_req) begin
                    if (32'(i_item.used_raw) > NUM_ENTRIES) begin
                        n_used = CNT_W'(NUM_ENTRIES);
                    end else begin
                        n_used = CNT_W'(i_item.used_raw);
                    end
                    n_seq_idx = '0;
                    n_state   = (n_used == '0) ? ST_TRES : ST_WALK;
                end
            end
            ST_WALK: begin
                tok_vld = 1'b1;
                if (adv) begin
                    if ((r_seq_idx + CNT_W'(1)) == r_used) begin
                        n_state = ST_TRES;
                    end else begin
                        n_seq_idx = r_seq_idx + CNT_W'(1);
                    end
                end
            end
            ST_TRES: begin
                tok_vld  = 1'b1;
                tok.kind = etrs_pkg::TOK_RESID;
                if (adv) begin
                    n_state = ST_TFLSH;
                end
            end
            ST_TFLSH: begin
                tok_vld  = 1'b1;
                tok.kind = etrs_pkg::TOK_FLUSH;
                if (adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign s4_diff = r_s3_lo - r_s3_ent_lo;

    always_comb begin
        hold_final      = r_hold;
        hold_final.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_s4_vld   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_s1_vld  <= tok_vld;
                r_s2_vld  <= r_s1_vld;
                r_s3_vld  <= r_s2_vld;
                r_s4_vld  <= r_s3_vld;
                if (r_s4_vld) begin
                    case (r_s4_tok.kind)
                        etrs_pkg::TOK_ENTRY: begin
                            if (r_s4_hit) begin
                                r_out_vld  <= r_hold_vld;
                                r_hold_vld <= 1'b1;
                            end else begin
                                r_out_vld <= 1'b0;
                            end
                        end
                        etrs_pkg::TOK_RESID: begin
                            if (r_issued < ISS_W'(r_req_len)) begin
                                r_out_vld  <= r_hold_vld;
                                r_hold_vld <= 1'b1;
                            end else begin
                                r_out_vld <= 1'b0;
                            end
                        end
                        etrs_pkg::TOK_FLUSH: begin
                            r_out_vld  <= r_hold_vld;
                            r_hold_vld <= 1'b0;
                        end
                        default: begin
                            r_out_vld <= 1'b0;
                        end
                    endcase
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    // Table, read registered, and the pipeline datapath.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_start[AW'(i_item.entry_index)] <= i_item.entry_start;
            mem_count[AW'(i_item.entry_index)] <= i_item.entry_count;
        end
        if (load_req) begin
            r_used    <= n_used;
            r_req_lo  <= i_item.req_lo;
            r_req_hi  <= i_item.req_hi;
            r_req_len <= i_item.req_len;
        end
        r_seq_idx <= n_seq_idx;
        if (adv) begin
            r_s1_tok   <= tok;
            r_s1_start <= mem_start[r_seq_idx[AW-1:0]];
            r_s1_count <= mem_count[r_seq_idx[AW-1:0]];

            r_s2_tok    <= r_s1_tok;
            r_s2_ent_lo <= {1'b0, r_s1_start, {etrs_pkg::BLOCK_SHIFT{1'b0}}};
            r_s2_ent_hi <= {({1'b0, r_s1_start} + {1'b0, r_s1_count}),
                            {etrs_pkg::BLOCK_SHIFT{1'b0}}};

            r_s3_tok    <= r_s2_tok;
            r_s3_lo     <= (r_s2_ent_lo > r_req_lo) ? r_s2_ent_lo : r_req_lo;
            r_s3_hi     <= (r_s2_ent_hi < r_req_hi) ? r_s2_ent_hi : r_req_hi;
            r_s3_ent_lo <= r_s2_ent_lo;

            r_s4_tok    <= r_s3_tok;
            r_s4_hit    <= r_s3_lo < r_s3_hi;
            r_s4_bytes  <= etrs_pkg::LEN_W'(r_s3_hi - r_s3_lo);
            r_s4_off    <= etrs_pkg::LEN_W'(r_s3_lo - r_req_lo);
            r_s4_target <= s4_diff[etrs_pkg::BLOCK_SHIFT +: etrs_pkg::ENT_W];
        end
    end

    // The newest result waits in the hold register until the next one shows
    // whether it is the final beat of the request. The hold register always
    // carries last cleared, so only the flush sets it on the way out.
    always_ff @(posedge i_clk) begin
        if (load_req) begin
            r_issued <= '0;
        end
        if (adv && r_s4_vld) begin
            case (r_s4_tok.kind)
                etrs_pkg::TOK_ENTRY: begin
                    if (r_s4_hit) begin
                        r_out                 <= r_hold;
                        r_hold.kind           <= etrs_pkg::KIND_PIECE;
                        r_hold.hit_index      <= r_s4_tok.idx;
                        r_hold.request_offset <= r_s4_off;
                        r_hold.piece_bytes    <= r_s4_bytes;
                        r_hold.target_block   <= r_s4_target;
                        r_hold.last           <= 1'b0;
                        r_issued              <= r_issued + ISS_W'(r_s4_bytes);
                    end
                end
                etrs_pkg::TOK_RESID: begin
                    if (r_issued < ISS_W'(r_req_len)) begin
                        r_out                 <= r_hold;
                        r_hold.kind           <= etrs_pkg::KIND_RESID;
                        r_hold.hit_index      <= '0;
                        r_hold.request_offset <= '0;
                        r_hold.piece_bytes    <= r_req_len
                                                 - etrs_pkg::LEN_W'(r_issued);
                        r_hold.target_block   <= '0;
                        r_hold.last           <= 1'b0;
                    end
                end
                etrs_pkg::TOK_FLUSH: begin
                    r_out <= hold_final;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_vld;

    a_flush_empties_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s4_vld && r_s4_tok.kind == etrs_pkg::TOK_FLUSH) |=> !r_hold_vld)
        else $error("hold register still full after the flush of a request");

    a_resid_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.kind == etrs_pkg::KIND_RESID) |-> o_result.last)
        else $error("residual beat is not the final beat");

    a_piece_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.kind == etrs_pkg::KIND_PIECE)
        |-> (o_result.piece_bytes != '0))
        else $error("sub-request beat with zero bytes");

    a_load_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_req |=> !r_hold_vld)
        else $error("request started while a result was still held");

endmodule

[tb/extent_table_request_splitter_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extent_table_request_splitter_unit_tb
// Self-checking bench for the extent table request splitter.
// ----------------------------------------------------------------------------
// A queue of pending actions (input beats, register writes and sync points)
// feeds a clocked driver. Every accepted input beat updates a shadow extent
// table or is split against it, and the expected result beats are queued.
// A clocked monitor compares each output beat with the oldest expectation.
// Both sides stall at random; the receiver also holds off once for a long
// stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module extent_table_request_splitter_unit_tb;

    import etrs_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int N_SLOTS     = DEF_NUM_ENTRIES;
    localparam int SETTLE      = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 4000;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {ACT_BEAT, ACT_CFG, ACT_SYNC} t_act;

    typedef struct {
        t_act             act;
        logic             op;
        logic [IDX_W-1:0] entry_index;
        logic [ENT_W-1:0] start_block;
        logic [ENT_W-1:0] block_count;
        logic [ENT_W-1:0] req_block;
        logic [LEN_W-1:0] req_bytes;
        logic [CFG_W-1:0] cfg_value;
    } t_action;

    logic             i_clk               = 1'b0;
    logic             i_rst_n             = 1'b0;
    logic             i_valid             = 1'b0;
    logic             o_ready;
    logic             i_op                = OP_WRITE;
    logic [IDX_W-1:0] i_entry_index       = '0;
    logic [ENT_W-1:0] i_entry_start_block = '0;
    logic [ENT_W-1:0] i_entry_block_count = '0;
    logic [ENT_W-1:0] i_req_block         = '0;
    logic [LEN_W-1:0] i_req_bytes         = '0;
    logic             i_cfg_valid         = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data          = '0;
    logic             o_valid;
    logic             i_ready             = 1'b0;
    logic             o_kind;
    logic [IDX_W-1:0] o_hit_index;
    logic [LEN_W-1:0] o_request_offset;
    logic [LEN_W-1:0] o_piece_bytes;
    logic [ENT_W-1:0] o_target_block;
    logic             o_last;

    // Stimulus side: actions still to issue and the table as generated.
    t_action          pending[$];
    t_action          cur_beat;
    logic [ENT_W-1:0] gen_start[N_SLOTS];
    logic [ENT_W-1:0] gen_count[N_SLOTS];

    // Shadow of the block: extent table, register and expected result beats.
    logic [ENT_W-1:0] tbl_start[N_SLOTS];
    logic [ENT_W-1:0] tbl_count[N_SLOTS];
    logic [CFG_W-1:0] used_cfg = '0;
    t_result          expected_pieces[$];

    int quiet       = 0;
    int cycle_count = 0;
    int n_errors    = 0;
    int n_beats     = 0;
    int n_requests  = 0;
    int n_writes    = 0;
    int n_cfg       = 0;
    int n_results   = 0;
    int n_resid     = 0;
    int max_burst   = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    extent_table_request_splitter_unit u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_op                (i_op),
        .i_entry_index       (i_entry_index),
        .i_entry_start_block (i_entry_start_block),
        .i_entry_block_count (i_entry_block_count),
        .i_req_block         (i_req_block),
        .i_req_bytes         (i_req_bytes),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_kind              (o_kind),
        .o_hit_index         (o_hit_index),
        .o_request_offset    (o_request_offset),
        .o_piece_bytes       (o_piece_bytes),
        .o_target_block      (o_target_block),
        .o_last              (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [ENT_W-1:0] rand48();
        return ENT_W'({$urandom, $urandom});
    endfunction

    // Splits one request against the shadow table and queues its result beats.
    // The newest beat is held back one step so that last can be set on it.
    function automatic void split_request(input logic [ENT_W-1:0] blk,
                                          input logic [LEN_W-1:0] nbytes);
        logic [63:0] req_lo, req_hi, ent_lo, ent_hi, lo, hi, len, issued;
        int          n_used, n_out, i;
        t_result     held, r;
        bit          have_held;
        len       = (nbytes > MAX_REQ_BYTES) ? 64'(MAX_REQ_BYTES) : 64'(nbytes);
        n_used    = (used_cfg > N_SLOTS) ? N_SLOTS : int'(used_cfg);
        req_lo    = 64'(blk) << BLOCK_SHIFT;
        req_hi    = req_lo + len;
        issued    = '0;
        n_out     = 0;
        have_held = 1'b0;
        held      = '0;
        for (i = 0; i < n_used; i++) begin
            ent_lo = 64'(tbl_start[i]) << BLOCK_SHIFT;
            ent_hi = (64'(tbl_start[i]) + 64'(tbl_count[i])) << BLOCK_SHIFT;
            lo     = (ent_lo > req_lo) ? ent_lo : req_lo;
            hi     = (ent_hi < req_hi) ? ent_hi : req_hi;
            if (lo < hi) begin
                r.kind           = KIND_PIECE;
                r.hit_index      = IDX_W'(i);
                r.request_offset = LEN_W'(lo - req_lo);
                r.piece_bytes    = LEN_W'(hi - lo);
                r.target_block   = ENT_W'((lo - ent_lo) >> BLOCK_SHIFT);
                r.last           = 1'b0;
                if (have_held) expected_pieces.push_back(held);
                held      = r;
                have_held = 1'b1;
                issued    = issued + (hi - lo);
                n_out++;
            end
        end
        // Overlapping entries can issue more than was asked; no residual then.
        if (issued < len) begin
            r             = '0;
            r.kind        = KIND_RESID;
            r.piece_bytes = LEN_W'(len - issued);
            if (have_held) expected_pieces.push_back(held);
            held      = r;
            have_held = 1'b1;
            n_out++;
            n_resid++;
        end
        if (have_held) begin
            held.last = 1'b1;
            expected_pieces.push_back(held);
        end
        if (n_out > max_burst) max_burst = n_out;
    endfunction

    function automatic void take_beat(input t_action a);
        if (a.op == OP_WRITE) begin
            tbl_start[a.entry_index] = a.start_block;
            tbl_count[a.entry_index] = a.block_count;
            n_writes++;
        end else begin
            split_request(a.req_block, a.req_bytes);
            n_requests++;
        end
    endfunction

    task automatic queue_write(input int slot, input logic [ENT_W-1:0] start_block,
                               input logic [ENT_W-1:0] block_count);
        t_action a;
        a.act         = ACT_BEAT;
        a.op          = OP_WRITE;
        a.entry_index = IDX_W'(slot);
        a.start_block = start_block;
        a.block_count = block_count;
        a.req_block   = rand48();
        a.req_bytes   = LEN_W'($urandom);
        a.cfg_value   = '0;
        pending.push_back(a);
        gen_start[slot] = start_block;
        gen_count[slot] = block_count;
    endtask

    task automatic queue_request(input logic [ENT_W-1:0] blk, input logic [LEN_W-1:0] nbytes);
        t_action a;
        a.act         = ACT_BEAT;
        a.op          = OP_REQUEST;
        a.entry_index = IDX_W'($urandom);
        a.start_block = rand48();
        a.block_count = rand48();
        a.req_block   = blk;
        a.req_bytes   = nbytes;
        a.cfg_value   = '0;
        pending.push_back(a);
    endtask

    task automatic queue_marker(input t_act kind, input logic [CFG_W-1:0] value);
        t_action a;
        a.act         = kind;
        a.op          = OP_WRITE;
        a.entry_index = '0;
        a.start_block = '0;
        a.block_count = '0;
        a.req_block   = '0;
        a.req_bytes   = '0;
        a.cfg_value   = value;
        pending.push_back(a);
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return LEN_W'($urandom_range(1, 128) * BLOCK_BYTES);
            4, 5, 6:    return LEN_W'($urandom_range(1, MAX_REQ_BYTES));
            7:          return LEN_W'($urandom_range(1, 700));
            8:          return LEN_W'($urandom);
            default:    return ($urandom_range(0, 1) != 0) ? LEN_W'(MAX_REQ_BYTES) : '0;
        endcase
    endfunction

    // Loads all slots with a fresh layout, in shuffled slot order.
    task automatic queue_layout(input int shape);
        logic [ENT_W-1:0] st[N_SLOTS];
        logic [ENT_W-1:0] ct[N_SLOTS];
        logic [ENT_W-1:0] base, pos;
        int               order[N_SLOTS];
        int               i, j, t;
        base = rand48() >> $urandom_range(0, ENT_W - 1);
        pos  = base;
        for (i = 0; i < N_SLOTS; i++) begin
            case ($urandom_range(0, 15))
                0:       ct[i] = '0;
                1:       ct[i] = rand48();
                default: ct[i] = ENT_W'($urandom_range(1, 40));
            endcase
            case (shape)
                0, 1: begin
                    st[i] = pos;
                    pos   = pos + ct[i];
                end
                2, 3: begin
                    st[i] = pos;
                    pos   = pos + ct[i] + ENT_W'($urandom_range(1, 8));
                end
                4, 5:    st[i] = base + ENT_W'($urandom_range(0, 60));
                default: st[i] = rand48();
            endcase
            order[i] = i;
        end
        for (i = N_SLOTS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (i = 0; i < N_SLOTS; i++) queue_write(order[i], st[order[i]], ct[order[i]]);
    endtask

    task automatic note_error(input string what, input t_result want, input t_result got);
        n_errors++;
        if (n_errors <= 10) begin
            $display("Mismatch (%s) at cycle %0d:", what, cycle_count);
            $display("  expected kind %0d idx %0d off %0d bytes %0d blk %h last %0d",
                     want.kind, want.hit_index, want.request_offset, want.piece_bytes,
                     want.target_block, want.last);
            $display("  actual   kind %0d idx %0d off %0d bytes %0d blk %h last %0d",
                     got.kind, got.hit_index, got.request_offset, got.piece_bytes,
                     got.target_block, got.last);
        end
    endtask

    // Idle time with nothing in flight; register writes and sync points wait on it.
    always @(negedge i_clk) begin
        if (!i_rst_n || i_valid || i_cfg_valid || o_valid || expected_pieces.size() != 0) begin
            quiet <= 0;
        end else if (quiet < 100000) begin
            quiet <= quiet + 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d result beats outstanding",
                     cycle_count, expected_pieces.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Driver.
    always @(posedge i_clk) begin : driver
        bit go_beat, go_cfg;
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                take_beat(cur_beat);
                n_beats++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                used_cfg = i_cfg_data;
                n_cfg++;
            end
            if ((!i_valid || o_ready) && (!i_cfg_valid || o_cfg_ready)) begin
                go_beat = 1'b0;
                go_cfg  = 1'b0;
                if (pending.size() != 0) begin
                    case (pending[0].act)
                        ACT_BEAT: go_beat = (n_beats >= 70 && n_beats < 110) ||
                                            ($urandom_range(0, 99) >= 14);
                        ACT_CFG:  go_cfg  = (quiet >= SETTLE);
                        default:  if (quiet >= 1) void'(pending.pop_front());
                    endcase
                end
                if (go_beat) begin
                    cur_beat = pending.pop_front();
                    i_op                <= cur_beat.op;
                    i_entry_index       <= cur_beat.entry_index;
                    i_entry_start_block <= cur_beat.start_block;
                    i_entry_block_count <= cur_beat.block_count;
                    i_req_block         <= cur_beat.req_block;
                    i_req_bytes         <= cur_beat.req_bytes;
                end
                if (go_cfg) begin
                    i_cfg_data <= pending[0].cfg_value;
                    void'(pending.pop_front());
                end
                i_valid     <= go_beat;
                i_cfg_valid <= go_cfg;
            end
        end
    end

    // Monitor and receiver stalls.
    always @(posedge i_clk) begin : monitor
        t_result got, want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got.kind           = o_kind;
                got.hit_index      = o_hit_index;
                got.request_offset = o_request_offset;
                got.piece_bytes    = o_piece_bytes;
                got.target_block   = o_target_block;
                got.last           = o_last;
                n_results++;
                if (expected_pieces.size() == 0) begin
                    note_error("unexpected beat", '0, got);
                end else begin
                    want = expected_pieces.pop_front();
                    if (got !== want) note_error("wrong field", want, got);
                end
            end
            // One long hold-off while the sender is still offering beats.
            if (!hold_done && n_results >= 80 && i_valid) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (n_results >= 120 && n_results < 200) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 14);
            end
        end
    end

    initial begin : stimulus
        logic [ENT_W-1:0] blk;
        logic [CFG_W-1:0] cfg_val;
        int               ph, k, j, lim, waited;
        localparam logic [ENT_W-1:0] B    = 48'd1000;
        localparam logic [ENT_W-1:0] ONES = '1;

        // Nothing is in use after reset, so every byte comes back as residual.
        queue_request(48'd5, 17'd1000);
        queue_request(48'd0, 17'd0);
        // One-block entries with one-block gaps: a wide request hits all of them.
        for (k = 0; k < N_SLOTS; k++) queue_write(k, B + ENT_W'(2 * k), 48'd1);
        queue_marker(ACT_CFG, 4'd8);
        queue_request(B, 17'd8192);
        queue_request(B, 17'h1FFFF);
        queue_request(B + 48'd2, 17'd100);
        queue_request(B + 48'd2, 17'd700);
        queue_request(B + 48'd15, 17'd512);
        queue_write(0, 48'd0, ONES);
        queue_write(1, ONES, ONES);
        queue_write(2, 48'd64, 48'd10);
        queue_marker(ACT_CFG, 4'd15);
        queue_request(48'd0, 17'd65536);
        queue_request(ONES, 17'h1FFFF);
        queue_request(48'h8000_0000_0000, 17'd1024);
        queue_request(48'h7FFF_FFFF_FFFF, 17'd1);
        queue_marker(ACT_CFG, 4'd1);
        queue_request(48'd5, 17'h10001);
        queue_request(B + 48'd2, 17'd0);

        for (ph = 0; ph < 6; ph++) begin
            queue_layout($urandom_range(0, 6));
            case (ph)
                0:       cfg_val = 4'd8;
                1:       cfg_val = 4'd0;
                2:       cfg_val = 4'd15;
                3:       cfg_val = 4'd1;
                default: cfg_val = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 15))
                                                               : CFG_W'($urandom_range(4, 8));
            endcase
            queue_marker(ACT_CFG, cfg_val);
            for (k = 0; k < 15; k++) begin
                if (ph == 3 && k == 7) queue_marker(ACT_SYNC, '0);
                case ($urandom_range(0, 9))
                    0: queue_request(rand48(), pick_len());
                    1: begin
                        j = $urandom_range(0, N_SLOTS - 1);
                        queue_write(j, gen_start[(j + 1) % N_SLOTS] +
                                       ENT_W'($urandom_range(0, 20)),
                                    ENT_W'($urandom_range(0, 40)));
                    end
                    default: begin
                        j   = (cfg_val == 0 || cfg_val > N_SLOTS) ?
                              $urandom_range(0, N_SLOTS - 1) : $urandom_range(0, cfg_val - 1);
                        lim = (gen_count[j] > 40) ? 40 : int'(gen_count[j]);
                        blk = gen_start[j] + ENT_W'($urandom_range(0, lim + 2)) - 48'd2;
                        queue_request(blk, pick_len());
                    end
                endcase
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_valid || i_cfg_valid) @(negedge i_clk);
        waited = 0;
        while (quiet < SETTLE && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (expected_pieces.size() != 0) begin
            $display("%0d expected result beats never arrived", expected_pieces.size());
            n_errors += expected_pieces.size();
        end

        $display("Split %0d requests into %0d result beats (%0d residual, up to %0d each).",
                 n_requests, n_results, n_resid, max_burst);
        $display("Also %0d table writes and %0d register writes; %0d errors.",
                 n_writes, n_cfg, n_errors);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
